FILE: sv/bfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bus frame encoder package
// Shared types, codes and the CRC-16 byte update for the frame encoder.
// ----------------------------------------------------------------------------
package bfe_pkg;

    typedef struct packed {
        logic        command;
        logic [2:0]  frame_type;
        logic [31:0] destination_address;
        logic [31:0] sender_address;
        logic        sync_bit;
        logic [1:0]  sender_counter;
        logic [1:0]  receiver_counter;
        logic [4:0]  address_mask;
        logic [7:0]  payload_length;
        logic [7:0]  payload_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
        logic       frame_error;
    } result_t;

    localparam logic CMD_HEADER  = 1'b0;
    localparam logic CMD_PAYLOAD = 1'b1;

    localparam logic [2:0] FT_INFO = 3'd0;
    localparam logic [2:0] FT_ACK  = 3'd1;
    localparam logic [2:0] FT_DISC = 3'd2;
    localparam logic [2:0] FT_SYS  = 3'd3;
    localparam logic [2:0] FT_RESP = 3'd4;

    typedef enum logic [2:0] {
        JOB_INFO = 3'd0,
        JOB_DISC = 3'd1,
        JOB_SYS  = 3'd2,
        JOB_PAY  = 3'd3,
        JOB_ERR  = 3'd4,
        JOB_RESP = 3'd5
    } job_kind_t;

    // Work handed from the front end to the byte sequencer.
    typedef struct packed {
        job_kind_t   kind;
        logic [31:0] dst;
        logic [31:0] src;
        logic [7:0]  ctrl;
        logic [7:0]  data;
        logic        last;
    } job_t;

    typedef enum logic [15:0] {
        SL_IDLE   = 16'h0001,
        SL_START  = 16'h0002,
        SL_D3     = 16'h0004,
        SL_D2     = 16'h0008,
        SL_D1     = 16'h0010,
        SL_D0     = 16'h0020,
        SL_CTRL   = 16'h0040,
        SL_S3     = 16'h0080,
        SL_S2     = 16'h0100,
        SL_S1     = 16'h0200,
        SL_S0     = 16'h0400,
        SL_LEN    = 16'h0800,
        SL_PAY    = 16'h1000,
        SL_CRC_HI = 16'h2000,
        SL_CRC_LO = 16'h4000,
        SL_RAW    = 16'h8000
    } slot_t;

    localparam logic [15:0] CRC_POLY = 16'h1002;
    localparam logic [15:0] CRC_INIT = 16'hF1E2;

    localparam logic [7:0] SOF_FRAME   = 8'hFD;
    localparam logic [7:0] SOF_SYSTEM  = 8'hFE;
    localparam logic [7:0] DISC_REPLY  = 8'hF8;
    localparam logic [7:0] ESC_BYTE    = 8'hFC;
    localparam logic [7:0] ESC_MASK    = 8'h7F;
    localparam logic [7:0] CTRL_BASE   = 8'h10;
    localparam logic [7:0] CTRL_LONG   = 8'h08;
    localparam logic [7:0] CTRL_ONE    = 8'h01;
    localparam logic [7:0] CTRL_DISC   = 8'h03;
    localparam logic [7:0] FIXED_LEN   = 8'h02;
    localparam logic [7:0] LEN_EXTRA   = 8'h02;
    localparam logic [7:0] ERR_BYTE    = 8'h00;

    // One byte through the CRC, MSB first.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

FILE: sv/bus_frame_encoder_crc16_stuffing.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bus frame encoder with CRC-16 and byte stuffing
// Turns header and payload requests into escaped wire bytes, one per result.
// ----------------------------------------------------------------------------
// The byte sequencer sends one wire byte per cycle while the output queue has room; a
// payload request yields one wire byte, or two when escaped, plus the CRC bytes when it
// closes the frame. A header request's byte count is set by its frame type and its escaped bytes.
// Reset clears the queues, the open-frame state and the sequencer; no clearing pass.
module bus_frame_encoder_crc16_stuffing #(
    parameter int unsigned MAX_PAYLOAD = 128,
    parameter int          JOB_DEPTH   = 4,
    parameter int          OUT_DEPTH   = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  bfe_pkg::item_t   item,
    output logic             full,
    output logic             empty,
    input  logic             pop,
    output bfe_pkg::result_t result
);

    localparam int JW = $bits(bfe_pkg::job_t);
    localparam int RW = $bits(bfe_pkg::result_t);

    logic             job_full, job_push, job_empty, job_pop;
    bfe_pkg::job_t    job_wr, job_head;
    logic             res_full, res_push;
    bfe_pkg::result_t res_wr;

    bfe_front #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item     (item),
        .full     (full),
        .job_full (job_full),
        .job_push (job_push),
        .job      (job_wr)
    );

    bfe_fifo #(
        .WIDTH(JW),
        .DEPTH(JOB_DEPTH)
    ) u_job_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .wdata (job_wr),
        .full  (job_full),
        .pop   (job_pop),
        .rdata (job_head),
        .empty (job_empty)
    );

    bfe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (job_empty),
        .job_head  (job_head),
        .job_pop   (job_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_wr)
    );

    bfe_fifo #(
        .WIDTH(RW),
        .DEPTH(OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_wr),
        .full  (res_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

endmodule

FILE: sv/bfe_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bus frame encoder queue
// Small first-word-fall-through register queue with full and empty flags.
// ----------------------------------------------------------------------------
module bfe_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

FILE: sv/bfe_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bus frame encoder front end
// Accepts header and payload requests, tracks the open frame and queues jobs.
// ----------------------------------------------------------------------------
module bfe_front #(
    parameter int unsigned MAX_PAYLOAD = 128
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  bfe_pkg::item_t item,
    output logic           full,
    input  logic           job_full,
    output logic           job_push,
    output bfe_pkg::job_t  job
);

    logic       open_reg, open_next;
    logic [7:0] left_reg, left_next;
    logic       accept;
    logic [7:0] rc_field;

    assign full     = job_full;
    assign accept   = push && !job_full;
    assign rc_field = {1'b0, item.receiver_counter, 5'b00000};

    always_comb
    begin
        job       = '0;
        job.kind  = bfe_pkg::JOB_PAY;
        job.dst   = item.destination_address;
        job.src   = item.sender_address;
        job_push  = 1'b0;
        open_next = open_reg;
        left_next = left_reg;
        if (accept)
        begin
            if (item.command == bfe_pkg::CMD_PAYLOAD)
            begin
                // A payload request with no open frame is dropped silently.
                if (open_reg)
                begin
                    job.kind  = bfe_pkg::JOB_PAY;
                    job.data  = item.payload_byte;
                    job.last  = (left_reg == 8'd1);
                    job_push  = 1'b1;
                    left_next = left_reg - 8'd1;
                    if (left_reg == 8'd1)
                    begin
                        open_next = 1'b0;
                    end
                end
            end
            else
            begin
                case (item.frame_type)
                    bfe_pkg::FT_INFO, bfe_pkg::FT_ACK:
                    begin
                        open_next = 1'b0;
                        left_next = 8'd0;
                        job_push  = 1'b1;
                        if (item.payload_length > 8'(MAX_PAYLOAD))
                        begin
                            job.kind = bfe_pkg::JOB_ERR;
                        end
                        else
                        begin
                            job.kind = bfe_pkg::JOB_INFO;
                            if (item.frame_type == bfe_pkg::FT_INFO)
                            begin
                                job.ctrl = bfe_pkg::CTRL_BASE | {item.sync_bit, 7'b0000000}
                                         | rc_field | bfe_pkg::CTRL_LONG
                                         | {5'b00000, item.sender_counter, 1'b0};
                            end
                            else
                            begin
                                job.ctrl = bfe_pkg::CTRL_BASE | rc_field
                                         | bfe_pkg::CTRL_LONG | bfe_pkg::CTRL_ONE;
                            end
                            job.data = item.payload_length + bfe_pkg::LEN_EXTRA;
                            job.last = (item.payload_length == 8'd0);
                            if (item.payload_length != 8'd0)
                            begin
                                open_next = 1'b1;
                                left_next = item.payload_length;
                            end
                        end
                    end
                    bfe_pkg::FT_DISC:
                    begin
                        open_next = 1'b0;
                        left_next = 8'd0;
                        job_push  = 1'b1;
                        job.kind  = bfe_pkg::JOB_DISC;
                        job.ctrl  = bfe_pkg::CTRL_DISC | {item.address_mask, 3'b000};
                        job.data  = bfe_pkg::FIXED_LEN;
                        job.last  = 1'b1;
                    end
                    bfe_pkg::FT_SYS:
                    begin
                        open_next = 1'b0;
                        left_next = 8'd0;
                        job_push  = 1'b1;
                        job.kind  = bfe_pkg::JOB_SYS;
                        job.ctrl  = bfe_pkg::CTRL_BASE | rc_field | bfe_pkg::CTRL_ONE;
                        job.data  = bfe_pkg::FIXED_LEN;
                        job.last  = 1'b1;
                    end
                    bfe_pkg::FT_RESP:
                    begin
                        open_next = 1'b0;
                        left_next = 8'd0;
                        job_push  = 1'b1;
                        job.kind  = bfe_pkg::JOB_RESP;
                    end
                    default:
                    begin
                        // Unknown frame types leave everything as it was.
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
            left_reg <= 8'd0;
        end
        else
        begin
            open_reg <= open_next;
            left_reg <= left_next;
        end
    end

endmodule

FILE: sv/bfe_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bus frame encoder byte sequencer
// Walks each job byte by byte, runs the CRC and inserts escape bytes.
// ----------------------------------------------------------------------------
module bfe_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             job_empty,
    input  bfe_pkg::job_t    job_head,
    output logic             job_pop,
    input  logic             res_full,
    output logic             res_push,
    output bfe_pkg::result_t res
);

    bfe_pkg::slot_t slot_reg, slot_next, slot_after, first_slot;
    bfe_pkg::job_t  job_reg;
    logic [15:0]    crc_reg, crc_next;
    logic [7:0]     crc_lo_reg, crc_lo_next;
    logic           esc_reg, esc_next;
    logic [7:0]     b_raw;
    logic           body, special, need_esc, active, go, advance, load;

    always_comb
    begin
        case (slot_reg)
            bfe_pkg::SL_START:  b_raw = (job_reg.kind == bfe_pkg::JOB_SYS) ?
                                        bfe_pkg::SOF_SYSTEM : bfe_pkg::SOF_FRAME;
            bfe_pkg::SL_D3:     b_raw = job_reg.dst[31:24];
            bfe_pkg::SL_D2:     b_raw = job_reg.dst[23:16];
            bfe_pkg::SL_D1:     b_raw = job_reg.dst[15:8];
            bfe_pkg::SL_D0:     b_raw = job_reg.dst[7:0];
            bfe_pkg::SL_CTRL:   b_raw = job_reg.ctrl;
            bfe_pkg::SL_S3:     b_raw = job_reg.src[31:24];
            bfe_pkg::SL_S2:     b_raw = job_reg.src[23:16];
            bfe_pkg::SL_S1:     b_raw = job_reg.src[15:8];
            bfe_pkg::SL_S0:     b_raw = job_reg.src[7:0];
            bfe_pkg::SL_LEN:    b_raw = job_reg.data;
            bfe_pkg::SL_PAY:    b_raw = job_reg.data;
            bfe_pkg::SL_CRC_HI: b_raw = crc_reg[15:8];
            bfe_pkg::SL_CRC_LO: b_raw = crc_lo_reg;
            bfe_pkg::SL_RAW:    b_raw = (job_reg.kind == bfe_pkg::JOB_ERR) ?
                                        bfe_pkg::ERR_BYTE : bfe_pkg::DISC_REPLY;
            default:            b_raw = 8'h00;
        endcase
    end

    always_comb
    begin
        case (slot_reg)
            bfe_pkg::SL_START:  slot_after = (job_reg.kind == bfe_pkg::JOB_SYS) ?
                                             bfe_pkg::SL_D0 : bfe_pkg::SL_D3;
            bfe_pkg::SL_D3:     slot_after = bfe_pkg::SL_D2;
            bfe_pkg::SL_D2:     slot_after = bfe_pkg::SL_D1;
            bfe_pkg::SL_D1:     slot_after = bfe_pkg::SL_D0;
            bfe_pkg::SL_D0:     slot_after = bfe_pkg::SL_CTRL;
            bfe_pkg::SL_CTRL:   slot_after = (job_reg.kind == bfe_pkg::JOB_INFO) ?
                                             bfe_pkg::SL_S3 : bfe_pkg::SL_LEN;
            bfe_pkg::SL_S3:     slot_after = bfe_pkg::SL_S2;
            bfe_pkg::SL_S2:     slot_after = bfe_pkg::SL_S1;
            bfe_pkg::SL_S1:     slot_after = bfe_pkg::SL_S0;
            bfe_pkg::SL_S0:     slot_after = bfe_pkg::SL_LEN;
            bfe_pkg::SL_LEN,
            bfe_pkg::SL_PAY:    slot_after = job_reg.last ?
                                             bfe_pkg::SL_CRC_HI : bfe_pkg::SL_IDLE;
            bfe_pkg::SL_CRC_HI: slot_after = bfe_pkg::SL_CRC_LO;
            default:            slot_after = bfe_pkg::SL_IDLE;
        endcase
    end

    always_comb
    begin
        case (job_head.kind)
            bfe_pkg::JOB_INFO,
            bfe_pkg::JOB_DISC,
            bfe_pkg::JOB_SYS:  first_slot = bfe_pkg::SL_START;
            bfe_pkg::JOB_PAY:  first_slot = bfe_pkg::SL_PAY;
            default:           first_slot = bfe_pkg::SL_RAW;
        endcase
    end

    // The start byte and the single-byte results go out unescaped.
    assign body     = (slot_reg != bfe_pkg::SL_START) && (slot_reg != bfe_pkg::SL_RAW);
    assign special  = b_raw inside {bfe_pkg::ESC_BYTE, bfe_pkg::SOF_FRAME, bfe_pkg::SOF_SYSTEM};
    assign need_esc = body && special && !esc_reg;
    assign active   = (slot_reg != bfe_pkg::SL_IDLE);
    assign go       = active && !res_full;
    assign advance  = go && !need_esc;
    assign load     = !job_empty && (!active || (advance && slot_after == bfe_pkg::SL_IDLE));
    assign job_pop  = load;
    assign res_push = go;

    always_comb
    begin
        res.out_byte    = need_esc ? bfe_pkg::ESC_BYTE :
                          (esc_reg ? (b_raw & bfe_pkg::ESC_MASK) : b_raw);
        res.frame_end   = advance && ((slot_reg == bfe_pkg::SL_CRC_LO) ||
                                      (slot_reg == bfe_pkg::SL_RAW));
        res.frame_error = (slot_reg == bfe_pkg::SL_RAW) && (job_reg.kind == bfe_pkg::JOB_ERR);
    end

    always_comb
    begin
        slot_next   = slot_reg;
        crc_next    = crc_reg;
        crc_lo_next = crc_lo_reg;
        esc_next    = esc_reg;
        if (go)
        begin
            esc_next = need_esc;
        end
        if (advance)
        begin
            slot_next = slot_after;
            case (slot_reg)
                bfe_pkg::SL_START:  crc_next = bfe_pkg::crc_feed(bfe_pkg::CRC_INIT, b_raw);
                bfe_pkg::SL_CRC_HI:
                begin
                    // The low byte is sent as it stood before the high byte went in.
                    crc_lo_next = crc_reg[7:0];
                    crc_next    = bfe_pkg::crc_feed(crc_reg, b_raw);
                end
                bfe_pkg::SL_CRC_LO,
                bfe_pkg::SL_RAW:    crc_next = crc_reg;
                default:            crc_next = bfe_pkg::crc_feed(crc_reg, b_raw);
            endcase
        end
        if (load)
        begin
            slot_next = first_slot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= bfe_pkg::SL_IDLE;
            crc_reg  <= bfe_pkg::CRC_INIT;
            esc_reg  <= 1'b0;
        end
        else
        begin
            slot_reg <= slot_next;
            crc_reg  <= crc_next;
            esc_reg  <= esc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        crc_lo_reg <= crc_lo_next;
        if (load)
        begin
            job_reg <= job_head;
        end
    end

endmodule
